@@ hw/rtl/dfr_pkg.sv @@
package dfr_pkg;

  // register indexes on the configuration channel
  localparam logic [2:0] REG_START_BYTE       = 3'd0;
  localparam logic [2:0] REG_END_BYTE         = 3'd1;
  localparam logic [2:0] REG_PREAMBLE_BYTES   = 3'd2;
  localparam logic [2:0] REG_PREAMBLE_COUNT   = 3'd3;
  localparam logic [2:0] REG_BROADCAST_LENGTH = 3'd4;
  localparam logic [2:0] REG_IDLE_LIMIT       = 3'd5;

  // reset values of the registers
  localparam logic [7:0]  RST_START_BYTE       = 8'd250;
  localparam logic [7:0]  RST_END_BYTE         = 8'd243;
  localparam logic [31:0] RST_PREAMBLE_BYTES   = 32'd0;
  localparam logic [2:0]  RST_PREAMBLE_COUNT   = 3'd2;
  localparam logic [5:0]  RST_BROADCAST_LENGTH = 6'd14;
  localparam logic [15:0] RST_IDLE_LIMIT       = 16'd20;

  // smallest partial broadcast frame that an idle flush still sends
  localparam int IDLE_FLUSH_MIN = 8;

  // frame length field of a send command, wide enough for the largest store
  localparam int LEN_W = 7;

  typedef struct packed {
    logic [7:0]  start_byte;
    logic [7:0]  end_byte;
    logic [31:0] preamble_bytes;
    logic [2:0]  preamble_count;
    logic [5:0]  broadcast_length;
    logic [15:0] idle_limit;
  } cfg_t;

  typedef struct packed {
    logic             bank;
    logic [LEN_W-1:0] len;
    logic             delimited;
    logic [15:0]      drops;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_status_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } done_t;

endpackage

@@ hw/rtl/dfr_in_if.sv @@
interface dfr_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] data_byte;

  modport source (output valid, output func, output data_byte, input ready);
  modport sink (input valid, input func, input data_byte, output ready);
endinterface

@@ hw/rtl/dfr_out_if.sv @@
interface dfr_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  payload_byte;
  logic        is_delimited;
  logic [5:0]  frame_length;
  logic        last;
  logic [15:0] drop_count;

  modport source (
    output valid, output payload_byte, output is_delimited, output frame_length,
    output last, output drop_count, input ready
  );
  modport sink (
    input valid, input payload_byte, input is_delimited, input frame_length,
    input last, input drop_count, output ready
  );
endinterface

@@ hw/rtl/dfr_cfg_if.sv @@
interface dfr_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/dfr_ram.sv @@
module dfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hw/rtl/dfr_cmd_fifo.sv @@
module dfr_cmd_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  dfr_pkg::cmd_t         push_cmd,
  input  logic                  pop,
  output dfr_pkg::cmd_t         head,
  output dfr_pkg::fifo_status_t status
);

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  dfr_pkg::cmd_t  entries [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign head         = entries[rd_ptr];
  assign status.empty = (count == CW'(0));
  assign status.full  = (count == CW'(DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        entries[wr_ptr] <= push_cmd;
        wr_ptr          <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

@@ hw/rtl/dfr_front.sv @@
module dfr_front #(
  parameter int MAX_FRAME = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  dfr_in_if.sink                           item,
  input  dfr_pkg::cfg_t                    cfg,
  input  logic [1:0]                       bank_busy,
  output logic                             wr_en,
  output logic [$clog2(2*MAX_FRAME)-1:0]   wr_addr,
  output logic [7:0]                       wr_data,
  output logic                             push,
  output dfr_pkg::cmd_t                    push_cmd
);

  localparam int FILL_W = $clog2(MAX_FRAME + 1);
  localparam int ADDR_W = $clog2(2 * MAX_FRAME);
  localparam int LW     = dfr_pkg::LEN_W;

  typedef enum logic [1:0] {M_IDLE, M_DELIM, M_BCAST} mode_t;

  mode_t             mode, mode_next;
  logic [FILL_W-1:0] fill_count, fill_count_next;
  logic [2:0]        preamble_index, preamble_index_next;
  logic [15:0]       quiet_ticks, quiet_ticks_next;
  logic [15:0]       overflow_drops, overflow_drops_next;
  logic              wr_bank, wr_bank_next;

  logic              accept;
  logic [7:0]        b;
  logic [2:0]        eff_count;
  logic [7:0]        pre_sel;
  logic              store_full;
  logic [FILL_W-1:0] fill_inc;
  logic [FILL_W-1:0] bcast_fill;
  logic [15:0]       quiet_sat;
  logic              in_preamble;

  assign item.ready = !bank_busy[wr_bank];
  assign accept     = item.valid && item.ready;
  assign b          = item.data_byte;
  assign wr_data    = item.data_byte;

  always_comb begin
    case (cfg.preamble_count)
      3'd0:    eff_count = 3'd1;
      3'd1:    eff_count = 3'd1;
      3'd2:    eff_count = 3'd2;
      3'd3:    eff_count = 3'd3;
      3'd4:    eff_count = 3'd4;
      default: eff_count = 3'd4;
    endcase
  end

  assign pre_sel     = cfg.preamble_bytes[{preamble_index[1:0], 3'b000} +: 8];
  assign in_preamble = (preamble_index < eff_count);
  assign store_full  = (fill_count >= FILL_W'(MAX_FRAME));
  assign fill_inc    = fill_count + FILL_W'(1);
  assign bcast_fill  = store_full ? fill_count : fill_inc;
  assign quiet_sat   = (quiet_ticks == 16'hFFFF) ? quiet_ticks : quiet_ticks + 16'd1;

  // store address: bank base plus fill position
  assign wr_addr = wr_bank ? ADDR_W'(MAX_FRAME) + ADDR_W'(fill_count) : ADDR_W'(fill_count);

  always_comb begin
    mode_next           = mode;
    fill_count_next     = fill_count;
    preamble_index_next = preamble_index;
    quiet_ticks_next    = quiet_ticks;
    overflow_drops_next = overflow_drops;
    wr_bank_next        = wr_bank;
    wr_en               = 1'b0;
    push                = 1'b0;
    push_cmd.bank       = wr_bank;
    push_cmd.len        = LW'(fill_count);
    push_cmd.delimited  = 1'b0;
    push_cmd.drops      = overflow_drops;

    if (accept && !item.func) begin
      quiet_ticks_next = '0;
      case (mode)
        M_DELIM: begin
          if (b == cfg.end_byte) begin
            push_cmd.delimited = 1'b1;
            push               = (fill_count != '0);
            mode_next           = M_IDLE;
            fill_count_next     = '0;
            preamble_index_next = '0;
          end else if (b == cfg.start_byte) begin
            fill_count_next = '0;
          end else if (store_full) begin
            if (overflow_drops != 16'hFFFF) begin
              overflow_drops_next = overflow_drops + 16'd1;
            end
            mode_next           = M_IDLE;
            fill_count_next     = '0;
            preamble_index_next = '0;
          end else begin
            wr_en           = 1'b1;
            fill_count_next = fill_inc;
          end
        end
        M_BCAST: begin
          wr_en           = !store_full;
          fill_count_next = bcast_fill;
          if (in_preamble && (b != pre_sel)) begin
            mode_next           = M_IDLE;
            fill_count_next     = '0;
            preamble_index_next = '0;
          end else begin
            if (in_preamble) begin
              preamble_index_next = preamble_index + 3'd1;
            end
            if (LW'(bcast_fill) >= LW'(cfg.broadcast_length)) begin
              push_cmd.len        = LW'(bcast_fill);
              push                = 1'b1;
              mode_next           = M_IDLE;
              fill_count_next     = '0;
              preamble_index_next = '0;
            end else if (bcast_fill >= FILL_W'(MAX_FRAME)) begin
              // too long to ever complete: dropped without a count
              mode_next           = M_IDLE;
              fill_count_next     = '0;
              preamble_index_next = '0;
            end
          end
        end
        default: begin
          if (b == cfg.start_byte) begin
            mode_next           = M_DELIM;
            fill_count_next     = '0;
            preamble_index_next = '0;
          end else if (b == cfg.preamble_bytes[7:0]) begin
            // fill is zero in idle, so this lands at entry zero
            wr_en               = 1'b1;
            mode_next           = M_BCAST;
            fill_count_next     = FILL_W'(1);
            preamble_index_next = 3'd1;
          end
        end
      endcase
    end else if (accept) begin
      quiet_ticks_next = quiet_sat;
      if ((mode == M_DELIM || mode == M_BCAST) && fill_count != '0 &&
          quiet_sat >= cfg.idle_limit) begin
        push = (mode == M_BCAST) && (fill_count >= FILL_W'(dfr_pkg::IDLE_FLUSH_MIN));
        mode_next           = M_IDLE;
        fill_count_next     = '0;
        preamble_index_next = '0;
      end
    end

    if (push) begin
      wr_bank_next = ~wr_bank;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= M_IDLE;
      fill_count     <= '0;
      preamble_index <= '0;
      quiet_ticks    <= '0;
      overflow_drops <= '0;
      wr_bank        <= 1'b0;
    end else begin
      mode           <= mode_next;
      fill_count     <= fill_count_next;
      preamble_index <= preamble_index_next;
      quiet_ticks    <= quiet_ticks_next;
      overflow_drops <= overflow_drops_next;
      wr_bank        <= wr_bank_next;
    end
  end

endmodule

@@ hw/rtl/dfr_back.sv @@
module dfr_back #(
  parameter int MAX_FRAME = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  dfr_pkg::fifo_status_t            fifo_status,
  input  dfr_pkg::cmd_t                    head,
  output logic                             pop,
  output logic                             rd_en,
  output logic [$clog2(2*MAX_FRAME)-1:0]   rd_addr,
  input  logic [7:0]                       rd_data,
  output dfr_pkg::done_t                   done,
  dfr_out_if.source                        result
);

  localparam int ADDR_W = $clog2(2 * MAX_FRAME);
  localparam int KW     = $clog2(MAX_FRAME);
  localparam int LW     = dfr_pkg::LEN_W;

  typedef enum logic [1:0] {B_IDLE, B_READ, B_LOAD, B_HOLD} state_t;

  state_t        state;
  dfr_pkg::cmd_t cur;
  logic [KW-1:0] k;
  logic          is_last;

  assign pop     = (state == B_IDLE) && !fifo_status.empty;
  assign rd_en   = (state == B_READ);
  assign rd_addr = cur.bank ? ADDR_W'(MAX_FRAME) + ADDR_W'(k) : ADDR_W'(k);
  assign is_last = ((LW'(k) + LW'(1)) == cur.len);

  assign done.valid = (state == B_HOLD) && result.ready && result.last;
  assign done.bank  = cur.bank;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= B_IDLE;
      result.valid <= 1'b0;
      k            <= '0;
    end else begin
      case (state)
        B_IDLE: begin
          if (!fifo_status.empty) begin
            cur   <= head;
            k     <= '0;
            state <= B_READ;
          end
        end
        B_READ: begin
          state <= B_LOAD;
        end
        B_LOAD: begin
          result.valid        <= 1'b1;
          result.payload_byte <= rd_data;
          result.is_delimited <= cur.delimited;
          result.frame_length <= cur.len[5:0];
          result.last         <= is_last;
          result.drop_count   <= cur.drops;
          state               <= B_HOLD;
        end
        B_HOLD: begin
          if (result.ready) begin
            result.valid <= 1'b0;
            if (result.last) begin
              state <= B_IDLE;
            end else begin
              k     <= k + KW'(1);
              state <= B_READ;
            end
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/sof_eof_and_preamble_deframer_top.sv @@
// first byte of a frame: its send command is queued, then the back fsm takes it and passes read and load before valid
// throughput: one input transaction per cycle while the store bank being filled is free
// output: each byte passes read, load and hold of the back fsm; the next byte is read only once this one is taken
// input stalls only while both store banks hold frames not yet fully sent
// reset: synchronous, clears mode, counters, queue and output valid, loads register defaults;
// frame store contents stay undefined and get no clearing pass
module sof_eof_and_preamble_deframer_top #(
  parameter int MAX_FRAME = 32
) (
  input  logic       clk,
  input  logic       rst,
  dfr_in_if.sink     item,
  dfr_out_if.source  result,
  dfr_cfg_if.sink    cfg
);

  // two banks of MAX_FRAME bytes: the front fills one while the back sends the other
  localparam int ADDR_W = $clog2(2 * MAX_FRAME);

  dfr_pkg::cfg_t         cfg_regs;
  logic [1:0]            bank_busy;

  logic                  wr_en;
  logic [ADDR_W-1:0]     wr_addr;
  logic [7:0]            wr_data;
  logic                  rd_en;
  logic [ADDR_W-1:0]     rd_addr;
  logic [7:0]            rd_data;

  logic                  push;
  dfr_pkg::cmd_t         push_cmd;
  logic                  pop;
  dfr_pkg::cmd_t         head;
  dfr_pkg::fifo_status_t fifo_status;
  dfr_pkg::done_t        done;

  // configuration writes are always taken
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.start_byte       <= dfr_pkg::RST_START_BYTE;
      cfg_regs.end_byte         <= dfr_pkg::RST_END_BYTE;
      cfg_regs.preamble_bytes   <= dfr_pkg::RST_PREAMBLE_BYTES;
      cfg_regs.preamble_count   <= dfr_pkg::RST_PREAMBLE_COUNT;
      cfg_regs.broadcast_length <= dfr_pkg::RST_BROADCAST_LENGTH;
      cfg_regs.idle_limit       <= dfr_pkg::RST_IDLE_LIMIT;
    end else if (cfg.valid) begin
      case (cfg.index)
        dfr_pkg::REG_START_BYTE:       cfg_regs.start_byte       <= cfg.data[7:0];
        dfr_pkg::REG_END_BYTE:         cfg_regs.end_byte         <= cfg.data[7:0];
        dfr_pkg::REG_PREAMBLE_BYTES:   cfg_regs.preamble_bytes   <= cfg.data;
        dfr_pkg::REG_PREAMBLE_COUNT:   cfg_regs.preamble_count   <= cfg.data[2:0];
        dfr_pkg::REG_BROADCAST_LENGTH: cfg_regs.broadcast_length <= cfg.data[5:0];
        dfr_pkg::REG_IDLE_LIMIT:       cfg_regs.idle_limit       <= cfg.data[15:0];
        default: begin
          // index beyond the register list: ignored
        end
      endcase
    end
  end

  // bank busy from the send command push until the last byte's transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      bank_busy <= '0;
    end else begin
      if (push) begin
        bank_busy[push_cmd.bank] <= 1'b1;
      end
      if (done.valid) begin
        bank_busy[done.bank] <= 1'b0;
      end
    end
  end

  // front: classifies bytes and ticks, fills the store, issues send commands
  dfr_front #(.MAX_FRAME(MAX_FRAME)) u_front (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cfg       (cfg_regs),
    .bank_busy (bank_busy),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  // frame store, both banks in one ram
  dfr_ram #(.WIDTH(8), .DEPTH(2 * MAX_FRAME)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // send command queue between front and back
  dfr_cmd_fifo u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .status   (fifo_status)
  );

  // back: reads a bank out byte by byte onto the result channel
  dfr_back #(.MAX_FRAME(MAX_FRAME)) u_back (
    .clk         (clk),
    .rst         (rst),
    .fifo_status (fifo_status),
    .head        (head),
    .pop         (pop),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .done        (done),
    .result      (result)
  );

`ifndef NO_ASSERTIONS
  // at most two frames in flight, so the queue never overflows
  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !fifo_status.full)
    else $error("send command pushed into a full queue");

  // front never sends from a bank still being read out
  a_push_free_bank: assert property (@(posedge clk) disable iff (rst)
    push |-> !bank_busy[push_cmd.bank])
    else $error("send command for a busy bank");

  // back only finishes a bank that was marked busy
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done.valid |-> bank_busy[done.bank])
    else $error("frame finished on a bank that was not busy");

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !result.valid)
    else $error("result valid right after reset");
`endif

endmodule

@@ verif/deframer_check.sv @@
package deframer_tb_pkg;

  // meaning of the func field of an input transaction
  localparam logic FUNC_RX_BYTE = 1'b0;
  localparam logic FUNC_MS_TICK = 1'b1;

endpackage

module deframer_check #(
  parameter int MAX_FRAME = 32
) (
  input  logic clk,
  input  logic rst,
  dfr_in_if    item,
  dfr_out_if   result,
  dfr_cfg_if   cfg,
  output int   mismatches,
  output int   pending
);
  import dfr_pkg::*;
  import deframer_tb_pkg::*;

  typedef enum logic [1:0] {
    ASM_IDLE  = 2'd0,
    ASM_DELIM = 2'd1,
    ASM_BCAST = 2'd2
  } asm_mode_e;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        is_delimited;
    logic [5:0]  frame_length;
    logic        last;
    logic [15:0] drop_count;
  } frame_byte_t;

  cfg_t        regs;
  asm_mode_e   mode;
  logic [7:0]  frame_mem [MAX_FRAME];
  int          fill;
  int          pre_idx;
  logic [15:0] quiet;
  logic [15:0] drops;
  frame_byte_t expected_bytes [$];

  function automatic void abandon_frame();
    mode    = ASM_IDLE;
    fill    = 0;
    pre_idx = 0;
  endfunction

  function automatic void release_frame(logic delimited);
    frame_byte_t fb;
    int n;
    n = (fill > MAX_FRAME) ? MAX_FRAME : fill;
    for (int k = 0; k < n; k++) begin
      fb.payload_byte = frame_mem[k];
      fb.is_delimited = delimited;
      fb.frame_length = 6'(n);
      fb.last         = (k == n - 1);
      fb.drop_count   = drops;
      expected_bytes.push_back(fb);
    end
    abandon_frame();
  endfunction

  function automatic int preamble_len();
    int c;
    c = int'(regs.preamble_count);
    if (c < 1) c = 1;
    if (c > 4) c = 4;
    return c;
  endfunction

  function automatic logic [7:0] preamble_at(int i);
    return regs.preamble_bytes[(i % 4) * 8 +: 8];
  endfunction

  function automatic void keep_byte(logic [7:0] b);
    if (fill < MAX_FRAME) begin
      frame_mem[fill] = b;
      fill++;
    end
  endfunction

  function automatic void take_rx_byte(logic [7:0] b);
    quiet = '0;
    case (mode)
      ASM_DELIM: begin
        // end wins when start and end are the same byte
        if (b == regs.end_byte) release_frame(1'b1);
        else if (b == regs.start_byte) fill = 0;
        else if (fill >= MAX_FRAME) begin
          if (drops != 16'hFFFF) drops++;
          abandon_frame();
        end else keep_byte(b);
      end
      ASM_BCAST: begin
        keep_byte(b);
        if (pre_idx < preamble_len()) begin
          if (b != preamble_at(pre_idx)) begin
            abandon_frame();
            return;
          end
          pre_idx++;
        end
        if (fill >= int'(regs.broadcast_length)) release_frame(1'b0);
        else if (fill >= MAX_FRAME) abandon_frame();
      end
      default: begin
        if (b == regs.start_byte) begin
          mode    = ASM_DELIM;
          fill    = 0;
          pre_idx = 0;
        end else if (b == preamble_at(0)) begin
          mode = ASM_BCAST;
          fill = 0;
          keep_byte(b);
          pre_idx = 1;
        end else mode = ASM_IDLE;
      end
    endcase
  endfunction

  function automatic void take_ms_tick();
    if (quiet != 16'hFFFF) quiet++;
    if (mode == ASM_IDLE || fill == 0) return;
    if (quiet < regs.idle_limit) return;
    if (mode == ASM_BCAST && fill >= IDLE_FLUSH_MIN) release_frame(1'b0);
    else abandon_frame();
  endfunction

  function automatic void write_reg(logic [2:0] idx, logic [31:0] value);
    case (idx)
      REG_START_BYTE:       regs.start_byte       = value[7:0];
      REG_END_BYTE:         regs.end_byte         = value[7:0];
      REG_PREAMBLE_BYTES:   regs.preamble_bytes   = value;
      REG_PREAMBLE_COUNT:   regs.preamble_count   = value[2:0];
      REG_BROADCAST_LENGTH: regs.broadcast_length = value[5:0];
      REG_IDLE_LIMIT:       regs.idle_limit       = value[15:0];
      default: ;
    endcase
  endfunction

  function automatic void compare_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    frame_byte_t want;
    if (rst) begin
      regs.start_byte       = RST_START_BYTE;
      regs.end_byte         = RST_END_BYTE;
      regs.preamble_bytes   = RST_PREAMBLE_BYTES;
      regs.preamble_count   = RST_PREAMBLE_COUNT;
      regs.broadcast_length = RST_BROADCAST_LENGTH;
      regs.idle_limit       = RST_IDLE_LIMIT;
      abandon_frame();
      quiet      = '0;
      drops      = '0;
      mismatches = 0;
      expected_bytes.delete();
    end else begin
      if (result.valid && result.ready) begin
        if (expected_bytes.size() == 0) begin
          $error("payload_byte: expected nothing, got %0d", result.payload_byte);
          mismatches++;
        end else begin
          want = expected_bytes.pop_front();
          compare_field("payload_byte", want.payload_byte, result.payload_byte);
          compare_field("is_delimited", want.is_delimited, result.is_delimited);
          compare_field("frame_length", want.frame_length, result.frame_length);
          compare_field("last", want.last, result.last);
          compare_field("drop_count", want.drop_count, result.drop_count);
        end
      end
      if (cfg.valid && cfg.ready) write_reg(cfg.index, cfg.data);
      if (item.valid && item.ready) begin
        if (item.func == FUNC_MS_TICK) take_ms_tick();
        else take_rx_byte(item.data_byte);
      end
    end
    pending = expected_bytes.size();
  end

endmodule

@@ verif/tb_top.sv @@
module tb_top;
  import dfr_pkg::*;
  import deframer_tb_pkg::*;

  localparam int MAX_FRAME = 32;
  // random items per configuration phase, eight phases in all
  localparam int PHASE_ITEMS = 20;
  // marker for a tick in the directed list, low bits are the data byte
  localparam logic [8:0] TICK_ITEM = {FUNC_MS_TICK, 8'h00};

  typedef enum int {
    DELIM_CLOSED,
    DELIM_OVERFLOW,
    DELIM_TIMED_OUT
  } delim_kind_e;

  logic clk = 1'b0;
  logic rst;
  int   mismatches;
  int   pending;

  // sender burst state and count of items moved in the current phase
  int   burst_left;
  int   items_sent;

  // register values last written, used to shape the stimulus
  cfg_t cfg_shadow;

  dfr_in_if  item_ch ();
  dfr_out_if result_ch ();
  dfr_cfg_if cfg_ch ();

  sof_eof_and_preamble_deframer_top #(
    .MAX_FRAME (MAX_FRAME)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  // predicts every emitted byte and compares the output transactions
  deframer_check #(
    .MAX_FRAME (MAX_FRAME)
  ) frame_check (
    .clk        (clk),
    .rst        (rst),
    .item       (item_ch),
    .result     (result_ch),
    .cfg        (cfg_ch),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hard stop well beyond the slowest correct run
  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

  // receiver: switches between always ready, coin flip and long stalls
  initial begin
    int style_left;
    int style;
    result_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (style_left == 0) begin
        style      = $urandom_range(0, 2);
        style_left = $urandom_range(16, 160);
      end
      style_left--;
      case (style)
        0: result_ch.ready <= 1'b1;
        1: result_ch.ready <= 1'($urandom_range(0, 1));
        default: result_ch.ready <= ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  // one input transaction, with a random gap whenever a burst runs out
  task automatic put_item(logic func, logic [7:0] data_byte);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 20);
      if (gap > 0) begin
        @(negedge clk) item_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    item_ch.valid     <= 1'b1;
    item_ch.func      <= func;
    item_ch.data_byte <= data_byte;
    do @(posedge clk); while (!item_ch.ready);
    burst_left--;
    items_sent++;
  endtask

  task automatic put_byte(logic [7:0] b);
    put_item(FUNC_RX_BYTE, b);
  endtask

  // data byte is ignored on a tick, so it gets random bits anyway
  task automatic put_tick();
    put_item(FUNC_MS_TICK, 8'($urandom_range(0, 255)));
  endtask

  // sender pauses until every predicted byte has come out, then lets the
  // block settle since the last transaction may have caused nothing
  task automatic wait_drained();
    @(negedge clk) item_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (12) @(negedge clk);
    burst_left = 0;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk) cfg_ch.valid <= 1'b0;
  endtask

  // registers change only with the block drained
  task automatic set_config(cfg_t c);
    wait_drained();
    write_reg(REG_START_BYTE, {24'h0, c.start_byte});
    write_reg(REG_END_BYTE, {24'h0, c.end_byte});
    write_reg(REG_PREAMBLE_BYTES, c.preamble_bytes);
    write_reg(REG_PREAMBLE_COUNT, {29'h0, c.preamble_count});
    write_reg(REG_BROADCAST_LENGTH, {26'h0, c.broadcast_length});
    write_reg(REG_IDLE_LIMIT, {16'h0, c.idle_limit});
    cfg_shadow = c;
  endtask

  // any byte that is neither delimiter
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == cfg_shadow.start_byte || b == cfg_shadow.end_byte);
    return b;
  endfunction

  // enough quiet ticks to reach the idle limit, a few when it is far off
  task automatic quiet_ticks();
    if (cfg_shadow.idle_limit <= 16'd40) begin
      repeat ((cfg_shadow.idle_limit == 16'd0) ? 1 : int'(cfg_shadow.idle_limit)) put_tick();
    end else begin
      repeat ($urandom_range(1, 4)) put_tick();
    end
  endtask

  task automatic delim_frame(delim_kind_e kind);
    int n;
    int r;
    put_byte(cfg_shadow.start_byte);
    r = $urandom_range(0, 9);
    if (kind == DELIM_OVERFLOW) n = MAX_FRAME + 1 + $urandom_range(0, 2);
    else if (r == 0) n = 0;
    else if (r < 7) n = $urandom_range(1, 8);
    else n = $urandom_range(9, MAX_FRAME);
    for (int i = 0; i < n; i++) begin
      // an occasional repeated start restarts the buffer
      if (kind != DELIM_OVERFLOW && $urandom_range(0, 24) == 0) put_byte(cfg_shadow.start_byte);
      put_byte(plain_byte());
    end
    if (kind == DELIM_CLOSED) put_byte(cfg_shadow.end_byte);
    else if (kind == DELIM_TIMED_OUT) quiet_ticks();
  endtask

  // preamble then random content up to the configured length; sometimes
  // cut short and left to time out, sometimes with a broken preamble
  task automatic bcast_frame();
    int         total;
    int         pcount;
    bit         partial;
    bit         broken;
    logic [7:0] b;
    pcount = int'(cfg_shadow.preamble_count);
    if (pcount < 1) pcount = 1;
    if (pcount > 4) pcount = 4;
    total = int'(cfg_shadow.broadcast_length);
    if (total < 2) total = 2;
    if (total > MAX_FRAME + 2) total = MAX_FRAME + 2;
    partial = ($urandom_range(0, 4) == 0);
    broken  = ($urandom_range(0, 7) == 0);
    if (partial) total = $urandom_range(1, total);
    for (int k = 0; k < total; k++) begin
      if (k < pcount) begin
        b = cfg_shadow.preamble_bytes[(k % 4) * 8 +: 8];
        if (broken && k == pcount - 1) b = b ^ (8'h01 << $urandom_range(0, 7));
      end else b = 8'($urandom_range(0, 255));
      put_byte(b);
    end
    if (partial) quiet_ticks();
  endtask

  task automatic line_noise();
    repeat ($urandom_range(1, 5)) begin
      if ($urandom_range(0, 2) == 0) put_tick();
      else put_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // mostly well-formed frames with random content, some noise
  task automatic random_phase(int count);
    int r;
    items_sent = 0;
    while (items_sent < count) begin
      r = $urandom_range(0, 9);
      if (r < 4) delim_frame(($urandom_range(0, 19) == 0) ? DELIM_OVERFLOW : DELIM_CLOSED);
      else if (r < 8) bcast_frame();
      else if (r == 8) line_noise();
      else delim_frame(DELIM_TIMED_OUT);
    end
  endtask

  initial begin
    logic [8:0] seq [$];
    cfg_t       next_cfg;

    rst               <= 1'b1;
    item_ch.valid     <= 1'b0;
    item_ch.func      <= FUNC_RX_BYTE;
    item_ch.data_byte <= 8'h00;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= REG_START_BYTE;
    cfg_ch.data       <= 32'h0;
    burst_left = 0;
    cfg_shadow.start_byte       = RST_START_BYTE;
    cfg_shadow.end_byte         = RST_END_BYTE;
    cfg_shadow.preamble_bytes   = RST_PREAMBLE_BYTES;
    cfg_shadow.preamble_count   = RST_PREAMBLE_COUNT;
    cfg_shadow.broadcast_length = RST_BROADCAST_LENGTH;
    cfg_shadow.idle_limit       = RST_IDLE_LIMIT;

    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // register defaults: an overflow first, so the drop count shows up in
    // the frames that follow
    delim_frame(DELIM_OVERFLOW);
    delim_frame(DELIM_CLOSED);
    bcast_frame();
    random_phase(PHASE_ITEMS);

    // directed list: preamble 55 00, frame length 10, one tick to flush
    next_cfg = '{8'h7E, 8'h7F, 32'hA5C3_0055, 3'd2, 6'd10, 16'd1};
    set_config(next_cfg);
    seq = {
      // delimited frame with byte extremes
      9'h07E, 9'h000, 9'h0FF, 9'h07F,
      // repeated start restarts the buffer
      9'h07E, 9'h011, 9'h07E, 9'h022, 9'h07F,
      // end with an empty buffer sends nothing
      9'h07E, 9'h07F,
      // stray byte in idle is ignored
      9'h012,
      // full broadcast frame
      9'h055, 9'h000, 9'h080, 9'h001, 9'h002, 9'h004, 9'h008, 9'h010, 9'h020, 9'h040,
      // preamble mismatch drops back to idle
      9'h055, 9'h001,
      // partial broadcast of eight bytes goes out on the idle flush
      9'h055, 9'h000, 9'h0C3, 9'h0A5, 9'h03C, 9'h05A, 9'h096, 9'h069, TICK_ITEM,
      // shorter partial broadcast is dropped
      9'h055, 9'h000, 9'h0AA, TICK_ITEM,
      // partial delimited frame is dropped
      9'h07E, 9'h033, TICK_ITEM,
      // open but empty delimited frame survives the flush, then closes empty
      9'h07E, TICK_ITEM, 9'h07F
    };
    foreach (seq[i]) put_item(seq[i][8], seq[i][7:0]);

    // start equal to end, preamble count and length above range, longest idle
    next_cfg = '{8'h33, 8'h33, 32'hFFFF_FFFF, 3'd7, 6'd63, 16'hFFFF};
    set_config(next_cfg);
    random_phase(PHASE_ITEMS);

    // start byte equals the first preamble byte, start takes priority
    next_cfg = '{8'h00, 8'hFF, 32'h1234_5600, 3'd2, 6'd12, 16'd5};
    set_config(next_cfg);
    random_phase(PHASE_ITEMS);

    // preamble count zero, length zero, idle limit zero
    next_cfg = '{8'hC0, 8'hC1, 32'hDEAD_BE01, 3'd0, 6'd0, 16'd0};
    set_config(next_cfg);
    random_phase(PHASE_ITEMS);

    // four preamble bytes with a length of one
    next_cfg = '{8'h5A, 8'hA5, $urandom, 3'd4, 6'd1, 16'd2};
    set_config(next_cfg);
    random_phase(PHASE_ITEMS);

    // one preamble byte, frame as large as the store
    next_cfg = '{8'($urandom_range(0, 127)), 8'($urandom_range(128, 255)),
                 $urandom, 3'd1, 6'd32, 16'd3};
    set_config(next_cfg);
    random_phase(PHASE_ITEMS);

    // random settings within the usual ranges
    repeat (2) begin
      next_cfg.start_byte       = 8'($urandom_range(0, 255));
      next_cfg.end_byte         = 8'($urandom_range(0, 255));
      next_cfg.preamble_bytes   = $urandom;
      next_cfg.preamble_count   = 3'($urandom_range(1, 4));
      next_cfg.broadcast_length = 6'($urandom_range(8, 20));
      next_cfg.idle_limit       = 16'($urandom_range(1, 10));
      set_config(next_cfg);
      random_phase(PHASE_ITEMS);
    end

    // drain, then give the block time to show any stray output
    wait_drained();
    repeat (20) @(negedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/dfr_pkg.sv
hw/rtl/dfr_in_if.sv
hw/rtl/dfr_out_if.sv
hw/rtl/dfr_cfg_if.sv
hw/rtl/dfr_ram.sv
hw/rtl/dfr_cmd_fifo.sv
hw/rtl/dfr_front.sv
hw/rtl/dfr_back.sv
hw/rtl/sof_eof_and_preamble_deframer_top.sv
verif/deframer_check.sv
verif/tb_top.sv
